// ----- sv/bqd_pkg.sv -----
// ----------------------------------------------------------------------------
// bqd_pkg
// Shared widths, register indexes, lane control type, sign-extension and
// saturation helpers for the biquad delay filter.
// ----------------------------------------------------------------------------
package bqd_pkg;

    localparam int IN_W     = 16;               // delay_frames
    localparam int COEF_W   = 32;               // Q4.28 coefficients, unsigned Q16.16 period
    localparam int OUT_W    = 32;               // filt_ns
    localparam int ACC_W    = 48;               // y and filter state
    localparam int FRAC     = 28;               // coefficient fraction bits
    localparam int PER_FRAC = 16;               // period fraction bits
    localparam int MC_W     = COEF_W + 1;       // multiplicand, room for unsigned period
    localparam int PROD_W   = MC_W + ACC_W;     // full lane product
    localparam int EXT_W    = PROD_W - FRAC;    // wide sum / rounded product width
    localparam int CNT_W    = $clog2(ACC_W);
    localparam int IDX_W    = 3;

    localparam logic [IDX_W-1:0] REG_B0     = 3'd0;
    localparam logic [IDX_W-1:0] REG_B1     = 3'd1;
    localparam logic [IDX_W-1:0] REG_B2     = 3'd2;
    localparam logic [IDX_W-1:0] REG_A1     = 3'd3;
    localparam logic [IDX_W-1:0] REG_A2     = 3'd4;
    localparam logic [IDX_W-1:0] REG_PERIOD = 3'd5;

    localparam logic [COEF_W-1:0] PERIOD_RESET = 32'd1365333333;

    typedef struct packed {
        logic clr;      // load multiplicand, clear accumulator
        logic en;       // consume one multiplier bit
        logic last;     // current bit is the sign bit (subtract)
    } smul_ctl_t;

    function automatic logic [EXT_W-1:0] sx_acc(input logic [ACC_W-1:0] v);
        return {{(EXT_W-ACC_W){v[ACC_W-1]}}, v};
    endfunction

    // Clamp a wide signed value to the 48-bit state range.
    function automatic logic [ACC_W-1:0] sat_acc(input logic [EXT_W-1:0] v);
        logic all0;
        logic all1;
        all0 = ~|v[EXT_W-1:ACC_W-1];
        all1 = &v[EXT_W-1:ACC_W-1];
        if (all0 || all1) begin
            return v[ACC_W-1:0];
        end else if (v[EXT_W-1]) begin
            return {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            return {1'b0, {(ACC_W-1){1'b1}}};
        end
    endfunction

endpackage

// ----- sv/biquad_lowpass_delay_filter_top.sv -----
// ----------------------------------------------------------------------------
// biquad_lowpass_delay_filter_top
// Low-pass biquad (transposed direct form II) on measured delays in frames,
// scaled by the sampling period to a rounded, saturated delay in ns.
// ----------------------------------------------------------------------------
//
//  channel   direction  beat contents
//  --------  ---------  ---------------------------------------------------
//  s_axis    in         tdata[15:0] delay_frames (signed)
//  m_axis    out        tdata[31:0] filt_ns (signed), tuser[0] saturated
//  cfg       in         cfg_index selects b0,b1,b2,a1,a2,period_ns; cfg_data
//
//  An item goes from the input beat to the output beat in these steps:
//  bit-serial b*x products in three lanes, the sum of y, a*y and y*period
//  products in the same lanes, rounding, and the load of the output
//  register. The next input beat can be taken with that output beat; the
//  input is closed while an item is in work, so one item at a time.
//  A stalled output holds the final step (and the filter state) until the
//  previous result is taken. Reset clears the filter state, coefficients to
//  zero, period to default.
//
module biquad_lowpass_delay_filter_top
    import bqd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,    // [15:0] delay_frames
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,    // [31:0] filt_ns
    output logic              m_axis_tuser,    // [0] saturated
    // configuration writes
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [COEF_W-1:0] cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MULX = 3'd1;
    localparam logic [2:0] ST_SUMY = 3'd2;
    localparam logic [2:0] ST_MULY = 3'd3;
    localparam logic [2:0] ST_RND  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    localparam int BX_LO = ACC_W - IN_W;            // b*x value sits here once all IN_W multiplier bits are in
    localparam int QD_W  = PROD_W - FRAC - PER_FRAC; // rounded delay width

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [ACC_W-1:0] bsr_reg;     // multiplier bits, shifted out LSB first

    logic [COEF_W-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg, period_reg;
    logic [ACC_W-1:0]  s1_reg, s2_reg;
    logic [ACC_W-1:0]  bx1_reg, bx2_reg, p1_reg, p2_reg;
    logic [OUT_W-1:0]  dns_reg;
    logic              dsat_reg;

    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_data_reg;
    logic              m_user_reg;

    logic              s_acc;
    logic              out_free;
    smul_ctl_t         lane_ctl;
    logic [MC_W-1:0]   mc0, mc1, mc2;
    logic [PROD_W-1:0] prod0, prod1, prod2;

    logic [EXT_W-1:0]  y_sum;
    logic [EXT_W-1:0]  q1, q2, r1, r2;
    logic              inc1, inc2, incd;
    logic [QD_W-1:0]   qd, rd;
    logic [EXT_W-1:0]  n1_sum, n2_sum;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // Lanes: b0/b1/b2 times x, then a1/a2/period times y.
    assign lane_ctl.clr  = s_acc || (state_reg == ST_SUMY);
    assign lane_ctl.en   = (state_reg == ST_MULX) || (state_reg == ST_MULY);
    assign lane_ctl.last = (cnt_reg == '0);

    always_comb begin
        if (state_reg == ST_IDLE) begin
            mc0 = {b0_reg[COEF_W-1], b0_reg};
            mc1 = {b1_reg[COEF_W-1], b1_reg};
            mc2 = {b2_reg[COEF_W-1], b2_reg};
        end else begin
            mc0 = {a1_reg[COEF_W-1], a1_reg};
            mc1 = {a2_reg[COEF_W-1], a2_reg};
            mc2 = {1'b0, period_reg};
        end
    end

    bqd_smul u_lane0 (.aclk(aclk), .ctl(lane_ctl), .mcand(mc0), .bit_in(bsr_reg[0]),
                      .prod(prod0));
    bqd_smul u_lane1 (.aclk(aclk), .ctl(lane_ctl), .mcand(mc1), .bit_in(bsr_reg[0]),
                      .prod(prod1));
    bqd_smul u_lane2 (.aclk(aclk), .ctl(lane_ctl), .mcand(mc2), .bit_in(bsr_reg[0]),
                      .prod(prod2));

    // y = b0*x + s1, saturated to the state range
    assign y_sum = sx_acc(prod0[BX_LO+ACC_W-1:BX_LO]) + sx_acc(s1_reg);

    // a*y >> FRAC, round half to even on the two's complement value
    assign q1   = prod0[PROD_W-1:FRAC];
    assign inc1 = prod0[FRAC-1] && ((|prod0[FRAC-2:0]) || prod0[FRAC]);
    assign r1   = q1 + EXT_W'(inc1);
    assign q2   = prod1[PROD_W-1:FRAC];
    assign inc2 = prod1[FRAC-1] && ((|prod1[FRAC-2:0]) || prod1[FRAC]);
    assign r2   = q2 + EXT_W'(inc2);

    // y*period >> (FRAC+PER_FRAC), same rounding
    assign qd   = prod2[PROD_W-1:FRAC+PER_FRAC];
    assign incd = prod2[FRAC+PER_FRAC-1]
                  && ((|prod2[FRAC+PER_FRAC-2:0]) || prod2[FRAC+PER_FRAC]);
    assign rd   = qd + QD_W'(incd);

    // next filter state
    assign n1_sum = sx_acc(bx1_reg) - sx_acc(p1_reg) + sx_acc(s2_reg);
    assign n2_sum = sx_acc(bx2_reg) - sx_acc(p2_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = ST_MULX;
                end
            end
            ST_MULX: begin
                if (cnt_reg == '0) begin
                    state_next = ST_SUMY;
                end
            end
            ST_SUMY: state_next = ST_MULY;
            ST_MULY: begin
                if (cnt_reg == '0) begin
                    state_next = ST_RND;
                end
            end
            ST_RND:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control, configuration, filter state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            b0_reg      <= '0;
            b1_reg      <= '0;
            b2_reg      <= '0;
            a1_reg      <= '0;
            a2_reg      <= '0;
            period_reg  <= PERIOD_RESET;
            s1_reg      <= '0;
            s2_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_B0:     b0_reg     <= cfg_data;
                    REG_B1:     b1_reg     <= cfg_data;
                    REG_B2:     b2_reg     <= cfg_data;
                    REG_A1:     a1_reg     <= cfg_data;
                    REG_A2:     a2_reg     <= cfg_data;
                    REG_PERIOD: period_reg <= cfg_data;
                    default: ;  // drop writes to unknown indexes
                endcase
            end
            if (state_reg == ST_DONE && out_free) begin
                s1_reg      <= sat_acc(n1_sum);
                s2_reg      <= sat_acc(n2_sum);
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                bsr_reg <= {{(ACC_W-IN_W){s_axis_tdata[IN_W-1]}}, s_axis_tdata};
                cnt_reg <= CNT_W'(IN_W - 1);
            end
            ST_MULX, ST_MULY: begin
                bsr_reg <= {1'b0, bsr_reg[ACC_W-1:1]};
                cnt_reg <= cnt_reg - 1'b1;
            end
            ST_SUMY: begin
                bsr_reg <= sat_acc(y_sum);
                bx1_reg <= prod1[BX_LO+ACC_W-1:BX_LO];
                bx2_reg <= prod2[BX_LO+ACC_W-1:BX_LO];
                cnt_reg <= CNT_W'(ACC_W - 1);
            end
            ST_RND: begin
                p1_reg <= sat_acc(r1);
                p2_reg <= sat_acc(r2);
                if ((&rd[QD_W-1:OUT_W-1]) || (~|rd[QD_W-1:OUT_W-1])) begin
                    dns_reg  <= rd[OUT_W-1:0];
                    dsat_reg <= 1'b0;
                end else begin
                    dns_reg  <= rd[QD_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                           : {1'b0, {(OUT_W-1){1'b1}}};
                    dsat_reg <= 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_data_reg <= dns_reg;
                    m_user_reg <= dsat_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- sv/bqd_smul.sv -----
// ----------------------------------------------------------------------------
// bqd_smul
// Serial-parallel signed multiplier lane: parallel multiplicand, multiplier
// shifted in one bit per enabled cycle, LSB first; product bits shift out low.
// ----------------------------------------------------------------------------
module bqd_smul
    import bqd_pkg::*;
(
    input  logic              aclk,
    input  smul_ctl_t         ctl,
    input  logic [MC_W-1:0]   mcand,
    input  logic              bit_in,
    output logic [PROD_W-1:0] prod
);

    logic [MC_W-1:0]  mc_reg;
    logic [MC_W-1:0]  acc_reg;
    logic [ACC_W-1:0] low_reg;
    logic [MC_W:0]    acc_x;
    logic [MC_W:0]    mc_x;
    logic [MC_W:0]    acc_next;

    assign acc_x = {acc_reg[MC_W-1], acc_reg};
    assign mc_x  = {mc_reg[MC_W-1], mc_reg};

    // Sign bit of the multiplier carries negative weight.
    always_comb begin
        if (!bit_in) begin
            acc_next = acc_x;
        end else if (ctl.last) begin
            acc_next = acc_x - mc_x;
        end else begin
            acc_next = acc_x + mc_x;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.clr) begin
            mc_reg  <= mcand;
            acc_reg <= '0;
            low_reg <= '0;
        end else if (ctl.en) begin
            acc_reg <= acc_next[MC_W:1];
            low_reg <= {acc_next[0], low_reg[ACC_W-1:1]};
        end
    end

    assign prod = {acc_reg, low_reg};

endmodule

// ----- sv/bqd_checker.sv -----
// ----------------------------------------------------------------------------
// bqd_checker
// Port-level checks on the biquad delay filter, bound to the top level.
// ----------------------------------------------------------------------------
module bqd_checker
    import bqd_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             m_axis_tuser
);

    // One item at a time: an accepted beat closes the input.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still open after accepted beat");

    // A fresh result is only produced while the input is closed.
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without work in progress");

    // The saturation flag only accompanies a clipped value.
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata == 32'h7FFF_FFFF || m_axis_tdata == 32'h8000_0000)
        else $error("saturated flag with unclipped value");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

endmodule

bind biquad_lowpass_delay_filter_top bqd_checker u_bqd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
